// File: hdl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds through reset
`define CHK_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/drt_pkg.sv
// Types and constants of the dirty rectangle tracker
package drt_pkg;

  localparam int COORD_BITS     = 16;
  localparam int EDGE_BITS      = COORD_BITS + 1;
  localparam int IN_TDATA_BITS  = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int CFG_IDX_BITS   = 2;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [EDGE_BITS-1:0]  edge_t;

  typedef enum logic [1:0] {
    FUNC_MARK_RECT = 2'd0,
    FUNC_MARK_ALL  = 2'd1,
    FUNC_RESOLVE   = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_DRAW    = 2'd0,
    ST_NOTHING = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SURFACE_W = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SURFACE_H = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_W  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_H  = 2'd3;

endpackage

// File: hdl/dirty_rect_tracker.sv
// Dirty rectangle tracker: bounding-box union of damage, resolved at present
// Pipeline: a request is held in the input register, then its result in the result register.
// Throughput: one request per cycle; marks never stall, a resolve waits only
//   while the result register is full and not taken.
// Reset: synchronous, active low; clears the box state, config and both valids.
module dirty_rect_tracker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // rect_left, rect_top, rect_w, rect_h
  input  logic [drt_pkg::IN_TDATA_BITS-1:0]    in_tdata,
  // func
  input  logic [1:0]                           in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // out_left, out_top, out_w, out_h
  output logic [drt_pkg::OUT_TDATA_BITS-1:0]   out_tdata,
  // status
  output logic [1:0]                           out_tuser,
  input  logic                                 cfg_we,
  input  logic [drt_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [drt_pkg::COORD_BITS-1:0]       cfg_data
);
  import drt_pkg::*;

  // input register
  logic        s_valid_r, s_valid_nxt;
  logic [1:0]  s_func_r;
  coord_t      s_left_r, s_top_r, s_w_r, s_h_r;

  // tracker state
  logic        pending_r, pending_nxt;
  logic        region_ok_r, region_ok_nxt;
  coord_t      box_left_r, box_left_nxt;
  coord_t      box_top_r, box_top_nxt;
  edge_t       box_right_r, box_right_nxt;
  edge_t       box_bottom_r, box_bottom_nxt;

  // configuration
  coord_t      surf_w_r, surf_h_r, win_w_r, win_h_r;

  // result register
  logic        out_valid_r, out_valid_nxt;
  status_t     out_status_r, out_status_nxt;
  coord_t      out_left_r, out_left_nxt;
  coord_t      out_top_r, out_top_nxt;
  coord_t      out_w_r, out_w_nxt;
  coord_t      out_h_r, out_h_nxt;

  logic        proc;
  logic        is_resolve;
  edge_t       mark_right, mark_bottom;
  edge_t       sw_e, sh_e, clip_r, clip_b;
  logic        box_bad;
  logic        mismatch;
  coord_t      sel_x, sel_y;
  edge_t       sel_r, sel_b, diff_w, diff_h;

  assign is_resolve = (s_func_r == FUNC_RESOLVE);
  assign proc       = s_valid_r && (!is_resolve || !out_valid_r || out_tready);
  assign in_tready  = !s_valid_r || proc;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = OUT_TDATA_BITS'({out_h_r, out_w_r, out_top_r, out_left_r});

  // datapath
  assign mark_right  = {1'b0, s_left_r} + {1'b0, s_w_r};
  assign mark_bottom = {1'b0, s_top_r} + {1'b0, s_h_r};

  assign sw_e    = {1'b0, surf_w_r};
  assign sh_e    = {1'b0, surf_h_r};
  assign clip_r  = (box_right_r > sw_e) ? sw_e : box_right_r;
  assign clip_b  = (box_bottom_r > sh_e) ? sh_e : box_bottom_r;
  assign box_bad = region_ok_r &&
                   ((box_left_r >= surf_w_r) || (box_top_r >= surf_h_r) ||
                    (clip_r <= {1'b0, box_left_r}) || (clip_b <= {1'b0, box_top_r}));
  assign mismatch = ((win_w_r != '0) && (win_w_r != surf_w_r)) ||
                    ((win_h_r != '0) && (win_h_r != surf_h_r));

  always_comb begin
    if (region_ok_r && !mismatch) begin
      sel_x = box_left_r;
      sel_y = box_top_r;
      sel_r = clip_r;
      sel_b = clip_b;
    end else begin
      sel_x = '0;
      sel_y = '0;
      sel_r = sw_e;
      sel_b = sh_e;
    end
  end

  assign diff_w = sel_r - {1'b0, sel_x};
  assign diff_h = sel_b - {1'b0, sel_y};

  always_comb begin
    s_valid_nxt    = (s_valid_r && !proc) || (in_tvalid && in_tready);
    pending_nxt    = pending_r;
    region_ok_nxt  = region_ok_r;
    box_left_nxt   = box_left_r;
    box_top_nxt    = box_top_r;
    box_right_nxt  = box_right_r;
    box_bottom_nxt = box_bottom_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_left_nxt   = out_left_r;
    out_top_nxt    = out_top_r;
    out_w_nxt      = out_w_r;
    out_h_nxt      = out_h_r;

    if (proc) begin
      unique case (func_t'(s_func_r))
        FUNC_MARK_RECT: begin
          if ((s_w_r != '0) && (s_h_r != '0) && !(pending_r && !region_ok_r)) begin
            if (!pending_r) begin
              box_left_nxt   = s_left_r;
              box_top_nxt    = s_top_r;
              box_right_nxt  = mark_right;
              box_bottom_nxt = mark_bottom;
              region_ok_nxt  = 1'b1;
            end else begin
              if (s_left_r < box_left_r)         box_left_nxt   = s_left_r;
              if (s_top_r < box_top_r)           box_top_nxt    = s_top_r;
              if (mark_right > box_right_r)      box_right_nxt  = mark_right;
              if (mark_bottom > box_bottom_r)    box_bottom_nxt = mark_bottom;
            end
            pending_nxt = 1'b1;
          end
        end
        FUNC_MARK_ALL: begin
          pending_nxt   = 1'b1;
          region_ok_nxt = 1'b0;
        end
        FUNC_RESOLVE: begin
          out_valid_nxt = 1'b1;
          out_left_nxt  = '0;
          out_top_nxt   = '0;
          out_w_nxt     = '0;
          out_h_nxt     = '0;
          if ((surf_w_r == '0) || (surf_h_r == '0)) begin
            out_status_nxt = ST_INVALID;
          end else begin
            pending_nxt   = 1'b0;
            region_ok_nxt = 1'b0;
            if (box_bad) begin
              out_status_nxt = ST_NOTHING;
            end else begin
              out_status_nxt = ST_DRAW;
              out_left_nxt   = sel_x;
              out_top_nxt    = sel_y;
              out_w_nxt      = diff_w[COORD_BITS-1:0];
              out_h_nxt      = diff_h[COORD_BITS-1:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r    <= 1'b0;
      pending_r    <= 1'b0;
      region_ok_r  <= 1'b0;
      box_left_r   <= '0;
      box_top_r    <= '0;
      box_right_r  <= '0;
      box_bottom_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      s_valid_r    <= s_valid_nxt;
      pending_r    <= pending_nxt;
      region_ok_r  <= region_ok_nxt;
      box_left_r   <= box_left_nxt;
      box_top_r    <= box_top_nxt;
      box_right_r  <= box_right_nxt;
      box_bottom_r <= box_bottom_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s_func_r <= in_tuser;
      s_left_r <= in_tdata[COORD_BITS-1:0];
      s_top_r  <= in_tdata[2*COORD_BITS-1:COORD_BITS];
      s_w_r    <= in_tdata[3*COORD_BITS-1:2*COORD_BITS];
      s_h_r    <= in_tdata[4*COORD_BITS-1:3*COORD_BITS];
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_left_r   <= out_left_nxt;
    out_top_r    <= out_top_nxt;
    out_w_r      <= out_w_nxt;
    out_h_r      <= out_h_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      surf_w_r <= '0;
      surf_h_r <= '0;
      win_w_r  <= '0;
      win_h_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SURFACE_W: surf_w_r <= cfg_data;
        CFG_SURFACE_H: surf_h_r <= cfg_data;
        CFG_WINDOW_W:  win_w_r  <= cfg_data;
        CFG_WINDOW_H:  win_h_r  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/drt_checker.sv
// Port-level checker for the dirty rectangle tracker, with its bind
`include "assert_macros.svh"

module drt_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [drt_pkg::OUT_TDATA_BITS-1:0]   out_tdata,
  input logic [1:0]                           out_tuser
);
  import drt_pkg::*;

  logic no_region;
  logic draw_size_ok;

  assign no_region    = (out_tdata == '0);
  assign draw_size_ok = (out_tdata[3*COORD_BITS-1:2*COORD_BITS] != '0) &&
                        (out_tdata[4*COORD_BITS-1:3*COORD_BITS] != '0);

  // stalled result holds
  `CHK_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // a refused present carries no region
  `CHK_ASSERT(a_invalid_zero, clk, rst_n, out_tvalid && (out_tuser == ST_INVALID) |-> no_region, "invalid surface with a region")

  `CHK_ASSERT(a_nothing_zero, clk, rst_n, out_tvalid && (out_tuser == ST_NOTHING) |-> no_region, "nothing to draw with a region")

  // a drawn region is never empty
  `CHK_ASSERT(a_draw_size, clk, rst_n, out_tvalid && (out_tuser == ST_DRAW) |-> draw_size_ok, "empty region drawn")

  `CHK_ASSERT_RST(a_reset_idle, clk, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind dirty_rect_tracker drt_checker u_drt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// File: tb/sv/tb_dirty_rect_tracker.sv
// Self-checking testbench for dirty_rect_tracker: predicted present regions against streamed results
`timescale 1ns / 100ps

module tb_dirty_rect_tracker;
  import drt_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 55;

  typedef struct {
    logic [1:0] func;
    coord_t     left;
    coord_t     top;
    coord_t     w;
    coord_t     h;
  } req_t;

  typedef struct {
    status_t status;
    coord_t  left;
    coord_t  top;
    coord_t  w;
    coord_t  h;
  } region_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // rect_left, rect_top, rect_w, rect_h
  logic [IN_TDATA_BITS-1:0] in_tdata = '0;
  // func
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // out_left, out_top, out_w, out_h
  logic [OUT_TDATA_BITS-1:0] out_tdata;
  // status
  logic [1:0] out_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [COORD_BITS-1:0] cfg_data = '0;

  // shadow of the block: surface settings and damage box
  coord_t surf_w = '0;
  coord_t surf_h = '0;
  coord_t win_w = '0;
  coord_t win_h = '0;
  bit     dirty = 1'b0;
  bit     box_valid = 1'b0;
  coord_t box_left = '0;
  coord_t box_top = '0;
  edge_t  box_right = '0;
  edge_t  box_bottom = '0;

  req_t    queued_reqs[$];
  region_t expected_regions[$];
  req_t    in_flight;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      errors = 0;
  int      quiet_cycles = 0;

  dirty_rect_tracker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void mark_damage(input coord_t x, input coord_t y,
                                      input coord_t w, input coord_t h);
    edge_t r;
    edge_t b;
    r = edge_t'(x) + edge_t'(w);
    b = edge_t'(y) + edge_t'(h);
    if (w == '0 || h == '0 || (dirty && !box_valid)) return;
    if (!dirty) begin
      box_left = x;
      box_top = y;
      box_right = r;
      box_bottom = b;
      box_valid = 1'b1;
    end else begin
      if (x < box_left) box_left = x;
      if (y < box_top) box_top = y;
      if (r > box_right) box_right = r;
      if (b > box_bottom) box_bottom = b;
    end
    dirty = 1'b1;
  endfunction

  function automatic region_t resolve_region();
    region_t res;
    edge_t   x;
    edge_t   y;
    edge_t   r;
    edge_t   b;
    bit      ok;
    res.status = ST_INVALID;
    res.left = '0;
    res.top = '0;
    res.w = '0;
    res.h = '0;
    if (surf_w == '0 || surf_h == '0) return res;
    x = '0;
    y = '0;
    r = edge_t'(surf_w);
    b = edge_t'(surf_h);
    ok = 1'b1;
    if (box_valid) begin
      x = edge_t'(box_left);
      y = edge_t'(box_top);
      r = box_right;
      b = box_bottom;
      if (x >= edge_t'(surf_w) || y >= edge_t'(surf_h)) begin
        ok = 1'b0;
      end else begin
        if (r > edge_t'(surf_w)) r = edge_t'(surf_w);
        if (b > edge_t'(surf_h)) b = edge_t'(surf_h);
        if (r <= x || b <= y) ok = 1'b0;
      end
    end
    dirty = 1'b0;
    box_valid = 1'b0;
    if (!ok) begin
      res.status = ST_NOTHING;
      return res;
    end
    // window size disagrees with the surface: present everything
    if ((win_w != '0 && win_w != surf_w) || (win_h != '0 && win_h != surf_h)) begin
      x = '0;
      y = '0;
      r = edge_t'(surf_w);
      b = edge_t'(surf_h);
    end
    res.status = ST_DRAW;
    res.left = coord_t'(x);
    res.top = coord_t'(y);
    res.w = coord_t'(r - x);
    res.h = coord_t'(b - y);
    return res;
  endfunction

  function automatic void track_request(input req_t rq);
    case (rq.func)
      FUNC_MARK_RECT: mark_damage(rq.left, rq.top, rq.w, rq.h);
      FUNC_MARK_ALL: begin
        dirty = 1'b1;
        box_valid = 1'b0;
      end
      FUNC_RESOLVE: expected_regions.push_back(resolve_region());
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function automatic void queue_req(input logic [1:0] f, input int unsigned l,
                                    input int unsigned t, input int unsigned w,
                                    input int unsigned h);
    req_t rq;
    rq.func = f;
    rq.left = coord_t'(l);
    rq.top = coord_t'(t);
    rq.w = coord_t'(w);
    rq.h = coord_t'(h);
    queued_reqs.push_back(rq);
  endfunction

  function automatic coord_t pick_coord(input int unsigned span);
    if ($urandom_range(99) < 25) return coord_t'($urandom);
    return coord_t'($urandom_range(span));
  endfunction

  function automatic req_t random_req();
    req_t        rq;
    int unsigned roll;
    int unsigned span;
    span = (surf_w > surf_h) ? surf_w : surf_h;
    span = span + span / 8 + 2;
    if (span > 65535) span = 65535;
    roll = $urandom_range(99);
    if (roll < 58) rq.func = FUNC_MARK_RECT;
    else if (roll < 66) rq.func = FUNC_MARK_ALL;
    else if (roll < 95) rq.func = FUNC_RESOLVE;
    else rq.func = FUNC_UNUSED;
    rq.left = pick_coord(span);
    rq.top = pick_coord(span);
    rq.w = ($urandom_range(99) < 6) ? coord_t'(0) : pick_coord(span / 2 + 1);
    rq.h = ($urandom_range(99) < 6) ? coord_t'(0) : pick_coord(span / 2 + 1);
    return rq;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input coord_t val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_SURFACE_W: surf_w = val;
      CFG_SURFACE_H: surf_h = val;
      CFG_WINDOW_W: win_w = val;
      CFG_WINDOW_H: win_h = val;
      default: ;
    endcase
  endtask

  task automatic set_surface(input coord_t sw, input coord_t sh,
                             input coord_t ww, input coord_t wh);
    write_reg(CFG_SURFACE_W, sw);
    write_reg(CFG_SURFACE_H, sh);
    write_reg(CFG_WINDOW_W, ww);
    write_reg(CFG_WINDOW_H, wh);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (queued_reqs.size() != 0 || in_tvalid || expected_regions.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) track_request(in_flight);
      if (!in_tvalid || in_tready) begin
        if (queued_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_flight = queued_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {in_flight.h, in_flight.w, in_flight.top, in_flight.left};
          in_tuser <= in_flight.func;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    region_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_regions.size() == 0) begin
        $error("unexpected result: status %0d", out_tuser);
        errors++;
      end else begin
        want = expected_regions.pop_front();
        check_field("status", want.status, out_tuser);
        check_field("out_left", want.left, out_tdata[15:0]);
        check_field("out_top", want.top, out_tdata[31:16]);
        check_field("out_w", want.w, out_tdata[47:32]);
        check_field("out_h", want.h, out_tdata[63:48]);
      end
    end
    out_tready <= rst_n ? ($urandom_range(99) >= recv_stall_pct) : 1'b0;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // no surface yet: invalid, damage kept
    queue_req(FUNC_RESOLVE, 0, 0, 0, 0);
    queue_req(FUNC_MARK_RECT, 10, 10, 5, 5);
    queue_req(FUNC_RESOLVE, 0, 0, 0, 0);
    drain();

    set_surface(100, 80, 0, 0);
    queue_req(FUNC_RESOLVE, 0, 0, 0, 0);
    queue_req(FUNC_RESOLVE, 0, 0, 0, 0);
    queue_req(FUNC_MARK_RECT, 3, 4, 0, 9);
    queue_req(FUNC_MARK_RECT, 3, 4, 9, 0);
    queue_req(FUNC_RESOLVE, 0, 0, 0, 0);
    queue_req(FUNC_MARK_RECT, 20, 30, 10, 10);
    queue_req(FUNC_MARK_RECT, 5, 50, 3, 3);
    queue_req(FUNC_RESOLVE, 0, 0, 0, 0);
    queue_req(FUNC_MARK_ALL, 0, 0, 0, 0);
    queue_req(FUNC_MARK_RECT, 1, 1, 1, 1);
    queue_req(FUNC_RESOLVE, 0, 0, 0, 0);
    queue_req(FUNC_MARK_RECT, 200, 10, 5, 5);
    queue_req(FUNC_RESOLVE, 0, 0, 0, 0);
    queue_req(FUNC_MARK_RECT, 90, 70, 50, 50);
    queue_req(FUNC_RESOLVE, 0, 0, 0, 0);
    queue_req(FUNC_MARK_RECT, 0, 0, 65535, 65535);
    queue_req(FUNC_RESOLVE, 0, 0, 0, 0);
    queue_req(FUNC_UNUSED, 65535, 65535, 65535, 65535);
    queue_req(FUNC_RESOLVE, 0, 0, 0, 0);
    drain();

    // widest surface, window height disagrees
    set_surface(65535, 65535, 65535, 1);
    queue_req(FUNC_MARK_RECT, 65534, 0, 65535, 1);
    queue_req(FUNC_RESOLVE, 0, 0, 0, 0);
    queue_req(FUNC_MARK_RECT, 65535, 65535, 65535, 65535);
    queue_req(FUNC_RESOLVE, 0, 0, 0, 0);
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_surface(640, 480, 0, 0);
        1: set_surface(1, 1, 1, 1);
        2: set_surface(65535, 65535, 65535, 65535);
        3: set_surface(0, 300, 0, 0);
        4: set_surface(320, 200, 320, 201);
        5: set_surface(256, 0, 0, 0);
        default: set_surface(coord_t'($urandom_range(2000, 1)),
                             coord_t'($urandom_range(65535, 1)),
                             ($urandom_range(1) != 0) ? coord_t'(0) : coord_t'($urandom),
                             ($urandom_range(1) != 0) ? coord_t'(0) : coord_t'($urandom));
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      repeat (PHASE_ITEMS) queued_reqs.push_back(random_req());
      drain();
    end

    if (errors == 0 && expected_regions.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/drt_pkg.sv
hdl/dirty_rect_tracker.sv
hdl/drt_checker.sv
tb/sv/tb_dirty_rect_tracker.sv
